/* src/isort_pkg.sv */
`default_nettype none

package isort_pkg;

   localparam int VALUE_W = 32;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic insert;   // insert the request value into the ordered cells
      logic emit;     // move the head cell to the result registers
   } cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic last_entry;   // exactly one value is left in the cells
   } status_type;

endpackage

`default_nettype wire

/* src/isort_datapath.sv */
`default_nettype none

module isort_datapath #(
   parameter int MAX_ITEMS = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire isort_pkg::cmd_type                  cmd,
   output isort_pkg::status_type                    status,
   input  wire logic signed [isort_pkg::VALUE_W-1:0] req_value,
   output logic                                     rsp_valid,
   output logic signed [isort_pkg::VALUE_W-1:0]     rsp_sorted_value,
   output logic                                     rsp_final_res,
   output logic                                     rsp_overflow
);

   localparam int FILL_W = $clog2(MAX_ITEMS + 1);

   logic signed [isort_pkg::VALUE_W-1:0] cell_ff [MAX_ITEMS];
   logic [MAX_ITEMS-1:0]                 gt;
   logic [FILL_W-1:0]                    fill_ff;
   logic                                 dropped_ff;
   logic                                 full;
   logic                                 rsp_valid_ff;
   logic signed [isort_pkg::VALUE_W-1:0] rsp_value_ff;
   logic                                 rsp_final_ff;
   logic                                 rsp_overflow_ff;

   assign full              = (fill_ff == FILL_W'(MAX_ITEMS));
   assign status.last_entry = (fill_ff == FILL_W'(1));

   // Each occupied cell compares its value with the arriving one.
   always_comb begin
      for (int i = 0; i < MAX_ITEMS; i++) begin
         gt[i] = (fill_ff > FILL_W'(i)) && (cell_ff[i] > req_value);
      end
   end

   // Cell chain: on insert with room, cells holding larger values move up
   // by one and the new value lands in the first larger cell or at the fill
   // point. On emit, every cell moves down by one toward the head.
   for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
      logic at_fill;
      assign at_fill = (fill_ff == FILL_W'(i));
      if (i == 0) begin : g_head
         always_ff @(posedge clock) begin
            if (cmd.insert && !full) begin
               if (gt[i] || at_fill) begin
                  cell_ff[i] <= req_value;
               end
            end else if (cmd.emit) begin
               if (MAX_ITEMS > 1) begin
                  cell_ff[i] <= cell_ff[(i + 1) % MAX_ITEMS];
               end
            end
         end
      end else begin : g_body
         always_ff @(posedge clock) begin
            if (cmd.insert && !full) begin
               if (gt[i-1]) begin
                  cell_ff[i] <= cell_ff[i-1];
               end else if (gt[i] || at_fill) begin
                  cell_ff[i] <= req_value;
               end
            end else if (cmd.emit) begin
               if (i < MAX_ITEMS - 1) begin
                  cell_ff[i] <= cell_ff[(i + 1) % MAX_ITEMS];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
         if (cmd.insert) begin
            if (full) begin
               dropped_ff <= 1'b1;
            end else begin
               fill_ff <= fill_ff + FILL_W'(1);
            end
         end else if (cmd.emit) begin
            fill_ff <= fill_ff - FILL_W'(1);
            if (status.last_entry) begin
               dropped_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_value_ff    <= cell_ff[0];
         rsp_final_ff    <= status.last_entry;
         rsp_overflow_ff <= dropped_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = rsp_value_ff;
   assign rsp_final_res    = rsp_final_ff;
   assign rsp_overflow     = rsp_overflow_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(MAX_ITEMS))
      else $error("fill count above capacity");

   a_cmd_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.insert && cmd.emit))
      else $error("insert and emit in the same cycle");

   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (fill_ff != '0))
      else $error("emit from empty cells");

   a_run_end: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && status.last_entry) |=> (fill_ff == '0) && !dropped_ff && rsp_final_ff)
      else $error("run end did not clear the list");

endmodule

`default_nettype wire

/* src/isort_ctrl.sv */
`default_nettype none

module isort_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic                   req_last,
   input  wire isort_pkg::status_type  status,
   output isort_pkg::cmd_type          cmd,
   output logic                        busy
);

   typedef enum logic [0:0] {
      ST_COLLECT,
      ST_EMIT
   } state_type;

   state_type state_ff;
   logic      busy_ff;

   assign cmd.insert = start && !busy_ff;
   assign cmd.emit   = (state_ff == ST_EMIT);
   assign busy       = busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
         busy_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_COLLECT: begin
               if (cmd.insert && req_last) begin
                  state_ff <= ST_EMIT;
                  busy_ff  <= 1'b1;
               end
            end
            ST_EMIT: begin
               if (status.last_entry) begin
                  state_ff <= ST_COLLECT;
                  busy_ff  <= 1'b0;
               end
            end
            default: begin
               state_ff <= ST_COLLECT;
               busy_ff  <= 1'b0;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

/* src/insertion_sorter_top.sv */
`default_nettype none

// Channel  | Ports                                                    | Transfer
// ---------+----------------------------------------------------------+------------------------
// request  | start, busy, req_value, req_last                         | start high, busy low
// response | rsp_valid, rsp_sorted_value, rsp_final_res, rsp_overflow | rsp_valid high, no stall
//
// Each value is inserted into the ordered cell chain, if it has room, in
// the cycle it is transferred, so a list streams in at one value per clock
// with busy low. A transfer with req_last set starts the emission: busy
// stays high while the stored values drain and one result leaves the head
// cell each cycle; busy falls as the final result is registered.
// Reset is synchronous and active high; it empties the list and clears the
// overflow flag. The receiver cannot stall, so results are never held.

module insertion_sorter_top #(
   parameter int MAX_ITEMS = 32
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic signed [isort_pkg::VALUE_W-1:0] req_value,
   input  wire logic                                 req_last,
   output logic                                      rsp_valid,
   output logic signed [isort_pkg::VALUE_W-1:0]      rsp_sorted_value,
   output logic                                      rsp_final_res,
   output logic                                      rsp_overflow
);

   // Commands and status between the controller and the cell chain.
   isort_pkg::cmd_type    cmd;
   isort_pkg::status_type status;

   // The controller decides when a request is taken and when the chain
   // drains; it never sees the data itself.
   isort_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_last (req_last),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   // The datapath holds the ordered cells, the fill count, the overflow
   // flag and the registered result.
   isort_datapath #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_final_res    (rsp_final_res),
      .rsp_overflow     (rsp_overflow)
   );

endmodule

`default_nettype wire
